/* hw/rtl/ialist_pkg.sv */
// ----------------------------------------------------------------------------
// ialist_pkg: shared types and constants of the indexed array list engine
// Command and result beat layouts, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ialist_pkg;

	// Default sizes of the list store.
	localparam int DEPTH_DEF     = 256;
	localparam int WORD_BITS_DEF = 32;

	// Fixed field widths of the command and result beats.
	localparam int W_ACTION = 3;
	localparam int W_POS    = 8;
	localparam int W_WORD   = 32;
	localparam int W_STATUS = 2;
	localparam int W_COUNT  = 9;

	// Action codes; code 7 is unused and does nothing.
	typedef enum logic [W_ACTION-1:0] {
		ACT_APPEND = 3'd0,
		ACT_DROP   = 3'd1,
		ACT_READ   = 3'd2,
		ACT_WRITE  = 3'd3,
		ACT_INSERT = 3'd4,
		ACT_ERASE  = 3'd5,
		ACT_CLEAR  = 3'd6
	} action_t;

	// Result status codes.
	typedef enum logic [W_STATUS-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_READ  = 2'd1,
		S_SHIFT = 2'd2
	} state_t;

	// One command beat.
	typedef struct packed {
		action_t                   action;
		logic [W_POS-1:0]          position;
		logic signed [W_WORD-1:0]  word_in;
	} request_t;

	// One result beat.
	typedef struct packed {
		logic signed [W_WORD-1:0]  word_out;
		status_t                   status;
		logic [W_COUNT-1:0]        count;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/ialist_ram.sv */
// ----------------------------------------------------------------------------
// ialist_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ialist_ram #(
	parameter int WIDTH = ialist_pkg::WORD_BITS_DEF,
	parameter int DEPTH = ialist_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/indexed_array_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_array_list_engine: ordered list of words with shifting insert/erase
// Keeps up to DEPTH words in a RAM plus a count. Insert and erase move the
// later entries one place per cycle through a single step counter.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  command   in   start & !busy        request (action, position, word_in)
//  result    out  done, one cycle      result (word_out, status, count)
//
//  Append, drop last, write, clear and flagged commands keep busy low, and
//  the result beat follows on the next cycle.
//  A read of a non-empty list holds busy for one cycle while the RAM reads.
//  Insert and erase move one entry per cycle over the single RAM read and
//  write port pair, and busy stays high until the last entry is written.
//  Reset clears the count and the sequencer; the RAM contents are not reset.
//  The receiver cannot stall: each result beat is valid for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_array_list_engine #(
	parameter int DEPTH     = ialist_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ialist_pkg::WORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire ialist_pkg::request_t  request,
	output      logic                  done,
	output      ialist_pkg::result_t   result
);

	import ialist_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > W_POS) ? CW : W_POS;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic                done_q, done_d;
	result_t             result_q, result_d;
	logic [CW-1:0]       k_q, k_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic                up_q, up_d;
	logic                pend_q, pend_d;
	logic [AW-1:0]       wr_addr_q, wr_addr_d;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata, ram_rdata;

	logic [WORD_BITS-1:0] w_in;
	logic                 index_ok, is_empty, is_full;
	logic [CW-1:0]        k_step;
	logic                 more;

	// Command word at store width, and the index and capacity checks.
	assign w_in     = WORD_BITS'($unsigned(request.word_in));
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign index_ok = (IW'(request.position) < IW'(count_q)) ||
	                  (is_empty && (request.position == '0));

	// Shared step unit: one adder moves the pointer, a direction-selected compare ends the pass.
	assign k_step = k_q + (up_q ? {CW{1'b1}} : CW'(1));
	assign more   = up_q ? (k_q > pos_q) : (k_step < count_q);

	// Sequencer: next state, RAM control and result beat.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		done_d    = 1'b0;
		result_d  = result_q;
		k_d       = k_q;
		pos_d     = pos_q;
		word_d    = word_q;
		up_d      = up_q;
		pend_d    = 1'b0;
		wr_addr_d = wr_addr_q;
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = ram_rdata;
		mem_re    = 1'b0;
		mem_raddr = k_step[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (start) begin
					result_d.word_out = '0;
					result_d.status   = ST_OK;
					done_d            = 1'b1;
					case (request.action)
						ACT_APPEND: begin
							if (is_full) begin
								result_d.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = w_in;
								count_d   = count_q + CW'(1);
							end
						end
						ACT_DROP: begin
							if (!is_empty) begin
								count_d = count_q - CW'(1);
							end
						end
						ACT_READ: begin
							if (!index_ok) begin
								result_d.status = ST_RANGE;
							end else if (!is_empty) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(request.position);
								done_d    = 1'b0;
								state_d   = S_READ;
							end
						end
						ACT_WRITE: begin
							if (!index_ok) begin
								result_d.status = ST_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(request.position);
								mem_wdata = w_in;
							end
						end
						ACT_INSERT: begin
							if (!index_ok) begin
								result_d.status = ST_RANGE;
							end else if (is_empty) begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = w_in;
								count_d   = count_q + CW'(1);
							end else if (is_full) begin
								result_d.status = ST_FULL;
							end else begin
								done_d  = 1'b0;
								state_d = S_SHIFT;
								up_d    = 1'b1;
								k_d     = count_q;
								pos_d   = CW'(request.position);
								word_d  = w_in;
							end
						end
						ACT_ERASE: begin
							if (!index_ok) begin
								result_d.status = ST_RANGE;
							end else if (!is_empty) begin
								done_d  = 1'b0;
								state_d = S_SHIFT;
								up_d    = 1'b0;
								k_d     = CW'(request.position);
								pos_d   = CW'(request.position);
							end
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
					result_d.count = W_COUNT'(count_d);
				end
			end
			S_READ: begin
				result_d.word_out = W_WORD'(ram_rdata);
				done_d            = 1'b1;
				state_d           = S_IDLE;
			end
			S_SHIFT: begin
				// Write back the entry read in the previous cycle.
				mem_we = pend_q;
				if (more) begin
					mem_re    = 1'b1;
					pend_d    = 1'b1;
					wr_addr_d = k_q[AW-1:0];
					k_d       = k_step;
				end else if (!pend_q) begin
					if (up_q) begin
						mem_we    = 1'b1;
						mem_waddr = pos_q[AW-1:0];
						mem_wdata = word_q;
						count_d   = count_q + CW'(1);
					end else begin
						count_d = count_q - CW'(1);
					end
					result_d.count = W_COUNT'(count_d);
					done_d         = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			pend_q  <= pend_d;
		end
	end

	// Payload and pointer registers.
	always_ff @(posedge clk) begin
		result_q  <= result_d;
		k_q       <= k_d;
		pos_q     <= pos_d;
		word_q    <= word_d;
		up_q      <= up_d;
		wr_addr_q <= wr_addr_d;
	end

	// Element store.
	ialist_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// The count never exceeds the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above store depth");

	// A pending write-back always follows a read issued in the previous cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(mem_re))
		else $error("write-back without a preceding read");

	// During a shift the read never targets the entry being written.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("shift read and write collide");

	// The count moves by one at most, or drops to zero on clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == $past(count_q) + CW'(1)) ||
			 (count_q == $past(count_q) - CW'(1)) || (count_q == '0)))
		else $error("element count jumped");

	// Every result beat follows an accepted command or a finishing sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(start && !busy) || $past(state_q != S_IDLE)))
		else $error("result beat without a command");

endmodule

`default_nettype wire
